[sv/tun_pkg.sv]
// Package with widths and pipeline record types of the triangle unit normal.
package tun_pkg;

  localparam int CW   = 16;          // vertex coordinate width
  localparam int FB   = 14;          // fraction bits of the normal
  localparam int OW   = 16;          // normal output width
  localparam int EW   = CW + 1;      // edge vector width
  localparam int PW   = 2 * EW;      // edge product width
  localparam int NW   = PW + 1;      // cross product width (signed)
  localparam int MW   = PW;          // cross product magnitude width
  localparam int SW   = 2 * MW + 2;  // sum of squares width
  localparam int RW   = SW / 2;      // square root width
  localparam int REMW = RW + 3;      // square root remainder width
  localparam int QB   = FB + 2;      // quotient bits: integer, fraction, round
  localparam int AW   = 3;           // configuration address width
  localparam int DW   = 32;          // configuration data width

  localparam logic [AW-1:0] ADDR_THRESHOLD = AW'(0);

  typedef logic [MW-1:0] mag_t;

  typedef struct packed {
    logic [SW-1:0]   rad;
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
    mag_t [2:0]      mag;
    logic [2:0]      neg;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0]         len;
    logic [2:0][RW:0]      rem;
    logic [2:0][QB-1:0]    quo;
    logic [2:0]            neg;
    logic                  degen;
  } dv_t;

endpackage

[sv/triangle_unit_normal.sv]
// Triangle unit normal: edges, cross product, square root and normalizing divide.
// The pipeline has 5 front stages, RW (35) square root stages, QB+1 (17) divide stages and
// one output register.
// Throughput: one triangle per cycle; every stage holds when the output is stalled.
// The pipelined bit-per-stage square root and divider set the depth.
// Reset clears all valid bits and sets the degenerate threshold to zero.
module triangle_unit_normal (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [tun_pkg::AW-1:0] paddr,
  input  logic [tun_pkg::DW-1:0] pwdata,
  output logic [tun_pkg::DW-1:0] prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     a_x_i,
  input  logic signed [15:0]     a_y_i,
  input  logic signed [15:0]     a_z_i,
  input  logic signed [15:0]     b_x_i,
  input  logic signed [15:0]     b_y_i,
  input  logic signed [15:0]     b_z_i,
  input  logic signed [15:0]     c_x_i,
  input  logic signed [15:0]     c_y_i,
  input  logic signed [15:0]     c_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [15:0]     normal_x_o,
  output logic signed [15:0]     normal_y_o,
  output logic signed [15:0]     normal_z_o,
  output logic                   degenerate_o
);
  import tun_pkg::*;

  // Configuration register. The user must write it only while the pipeline is empty; the block does not enforce this.
  logic [DW-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THRESHOLD) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
      thr_q <= pwdata;
    end
  end

  // The whole pipeline moves as one; a stalled result holds every stage.
  logic en;
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: edge vectors U = B - A and V = C - A.
  logic signed [EW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic                 e_v_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= EW'(b_x_i) - EW'(a_x_i);
      uy_q <= EW'(b_y_i) - EW'(a_y_i);
      uz_q <= EW'(b_z_i) - EW'(a_z_i);
      vx_q <= EW'(c_x_i) - EW'(a_x_i);
      vy_q <= EW'(c_y_i) - EW'(a_y_i);
      vz_q <= EW'(c_z_i) - EW'(a_z_i);
    end
  end

  // Stage 2: the edge products that the cross product components subtract in pairs.
  logic signed [PW-1:0] p_q [6];
  logic                 p_v_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW'(uy_q) * PW'(vz_q);
      p_q[1] <= PW'(uz_q) * PW'(vy_q);
      p_q[2] <= PW'(uz_q) * PW'(vx_q);
      p_q[3] <= PW'(ux_q) * PW'(vz_q);
      p_q[4] <= PW'(ux_q) * PW'(vy_q);
      p_q[5] <= PW'(uy_q) * PW'(vx_q);
    end
  end

  // Stage 3: cross product as sign and magnitude.
  logic signed [NW-1:0] n_d [3];
  mag_t [2:0]           mag_q;
  logic [2:0]           neg_q;
  logic                 n_v_q;
  always_comb begin
    n_d[0] = NW'(p_q[0]) - NW'(p_q[1]);
    n_d[1] = NW'(p_q[2]) - NW'(p_q[3]);
    n_d[2] = NW'(p_q[4]) - NW'(p_q[5]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= n_d[i][NW-1];
        mag_q[i] <= n_d[i][NW-1] ? MW'(-n_d[i]) : MW'(n_d[i]);
      end
    end
  end

  // Stage 4: squares of the magnitudes.
  logic [2*MW-1:0] sqr_q [3];
  mag_t [2:0]      mag4_q;
  logic [2:0]      neg4_q;
  logic            s_v_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= mag_q[i] * mag_q[i];
      end
      mag4_q <= mag_q;
      neg4_q <= neg_q;
    end
  end

  // Stage 5 feeds the square root: the sum of squares enters as the radicand.
  sq_t  sq_q [RW+1];
  logic sq_v_q [RW+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rad  <= SW'(sqr_q[0]) + SW'(sqr_q[1]) + SW'(sqr_q[2]);
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].mag  <= mag4_q;
      sq_q[0].neg  <= neg4_q;
    end
  end

  // Square root, one result bit per stage, two radicand bits taken each time.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] r_cat;
    logic [REMW-1:0] trial;
    always_comb begin
      r_cat = {sq_q[k].rem[REMW-3:0], sq_q[k].rad[SW-1:SW-2]};
      trial = REMW'({sq_q[k].root, 2'b01});
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1].rad <= {sq_q[k].rad[SW-3:0], 2'b00};
        sq_q[k+1].mag <= sq_q[k].mag;
        sq_q[k+1].neg <= sq_q[k].neg;
        if (r_cat >= trial) begin
          sq_q[k+1].rem  <= r_cat - trial;
          sq_q[k+1].root <= {sq_q[k].root[RW-2:0], 1'b1};
        end else begin
          sq_q[k+1].rem  <= r_cat;
          sq_q[k+1].root <= {sq_q[k].root[RW-2:0], 1'b0};
        end
      end
    end
  end

  // Divider entry: the length is compared with the threshold here.
  dv_t  dv_q [QB+1];
  logic dv_v_q [QB+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].len   <= sq_q[RW].root;
      dv_q[0].neg   <= sq_q[RW].neg;
      dv_q[0].degen <= !(sq_q[RW].root > RW'(thr_q));
      for (int i = 0; i < 3; i++) begin
        dv_q[0].rem[i] <= (RW+1)'(sq_q[RW].mag[i]);
        dv_q[0].quo[i] <= '0;
      end
    end
  end

  // Restoring divide of each magnitude by the length, one quotient bit a stage.
  // A component never exceeds the length, so the remainder stays below it.
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0] r_sh [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r_sh[i] = (k == 0) ? dv_q[k].rem[i] : {dv_q[k].rem[i][RW-1:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1].len   <= dv_q[k].len;
        dv_q[k+1].neg   <= dv_q[k].neg;
        dv_q[k+1].degen <= dv_q[k].degen;
        for (int i = 0; i < 3; i++) begin
          if (r_sh[i] >= (RW+1)'(dv_q[k].len)) begin
            dv_q[k+1].rem[i] <= r_sh[i] - (RW+1)'(dv_q[k].len);
            dv_q[k+1].quo[i] <= {dv_q[k].quo[i][QB-2:0], 1'b1};
          end else begin
            dv_q[k+1].rem[i] <= r_sh[i];
            dv_q[k+1].quo[i] <= {dv_q[k].quo[i][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output stage: round half away from zero, saturate at one, apply the sign.
  logic [QB-1:0]        rnd  [3];
  logic [QB-1:0]        sat  [3];
  logic signed [OW-1:0] comp [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = (dv_q[QB].quo[i] + QB'(1)) >> 1;
      sat[i]  = (rnd[i] > (QB'(1) << FB)) ? (QB'(1) << FB) : rnd[i];
      comp[i] = dv_q[QB].neg[i] ? -OW'(sat[i]) : OW'(sat[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degenerate_o <= dv_q[QB].degen;
      if (dv_q[QB].degen) begin
        normal_x_o <= '0;
        normal_y_o <= '0;
        normal_z_o <= OW'(1) << FB;
      end else begin
        normal_x_o <= comp[0];
        normal_y_o <= comp[1];
        normal_z_o <= comp[2];
      end
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      n_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= RW; k++) sq_v_q[k] <= 1'b0;
      for (int k = 0; k <= QB; k++) dv_v_q[k] <= 1'b0;
    end else if (en) begin
      e_v_q     <= in_valid_i;
      p_v_q     <= e_v_q;
      n_v_q     <= p_v_q;
      s_v_q     <= n_v_q;
      sq_v_q[0] <= s_v_q;
      for (int k = 0; k < RW; k++) sq_v_q[k+1] <= sq_v_q[k];
      dv_v_q[0] <= sq_v_q[RW];
      for (int k = 0; k < QB; k++) dv_v_q[k+1] <= dv_v_q[k];
      out_v_q   <= dv_v_q[QB];
    end
  end

  assign out_valid_o = out_v_q;

  // The input is held off exactly when a waiting result is stalled.
  a_stall_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output stall");

  // An accepted triangle occupies the first stage in the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> e_v_q)
    else $error("accepted transfer lost at pipeline entry");

  // A degenerate result carries the fallback normal.
  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == (OW'(1) << FB)))
    else $error("degenerate result without fallback normal");

  // The normalized z component never exceeds one in magnitude.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !degenerate_o) |->
      (normal_z_o <= $signed(OW'(1) << FB) && normal_z_o >= -$signed(OW'(1) << FB)))
    else $error("normal component out of range");

endmodule

[dv/tb_triangle_unit_normal.sv]
// Self-checking testbench for the triangle unit normal block.
module tb_triangle_unit_normal;
  import tun_pkg::*;

  // Clock, reset and every input of the block start at a known value.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [15:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic signed [15:0] c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  localparam int PIPE_DEPTH = 58;
  localparam int CYCLE_LIMIT = 400000;

  normal_t expected_normals[$];
  logic [31:0] threshold_model = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int unsigned long_hold = 0;
  int unsigned mismatch_count = 0;
  int unsigned normals_checked = 0;
  int unsigned degenerate_seen = 0;
  int unsigned cycle_count = 0;

  always #2 clk_i = ~clk_i;

  triangle_unit_normal dut (.*);

  // Round to nearest, ties away from zero, of mag * 2^FB / len, then saturate at one.
  function automatic logic signed [15:0] scale_to_unit(logic signed [40:0] comp,
                                                         logic [63:0] len);
    logic [127:0] mag;
    logic [127:0] quo;
    logic [127:0] rem;
    mag = comp < 0 ? 128'(-comp) : 128'(comp);
    quo = (mag << FB) / len;
    rem = (mag << FB) % len;
    if ((rem << 1) >= len) quo = quo + 1;
    if (quo > (128'd1 << FB)) quo = 128'd1 << FB;
    return comp < 0 ? -16'(quo) : 16'(quo);
  endfunction

  // Integer square root, floor, bit by bit.
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= s) root = trial;
    end
    return root;
  endfunction

  function automatic normal_t face_normal(logic signed [15:0] v[9]);
    logic signed [40:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] sum;
    logic [63:0] len;
    normal_t r;
    ux = 41'(v[3]) - 41'(v[0]); uy = 41'(v[4]) - 41'(v[1]); uz = 41'(v[5]) - 41'(v[2]);
    vx = 41'(v[6]) - 41'(v[0]); vy = 41'(v[7]) - 41'(v[1]); vz = 41'(v[8]) - 41'(v[2]);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    sum = 128'(128'(nx) * 128'(nx)) + 128'(128'(ny) * 128'(ny)) +
          128'(128'(nz) * 128'(nz));
    len = floor_sqrt(sum);
    if (len > 64'(threshold_model) && len != 0) begin
      r.nx = scale_to_unit(nx, len);
      r.ny = scale_to_unit(ny, len);
      r.nz = scale_to_unit(nz, len);
      r.degen = 1'b0;
    end else begin
      r.nx = '0; r.ny = '0; r.nz = 16'sd1 <<< FB; r.degen = 1'b1;
    end
    return r;
  endfunction

  // Receiver: random stall, or a long counted hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_recv && long_hold == 0) long_hold <= 300;
    if (long_hold > 1) begin
      out_stall_i <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (long_hold == 1) begin
      out_stall_i <= 1'b0;
      long_hold <= 0;
      hold_recv <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Checker: each result transfer against the oldest expected normal.
  always @(posedge clk_i) begin
    normal_t want;
    cycle_count <= cycle_count + 1;
    if (out_valid_o && !out_stall_i) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time,
                 normal_x_o, normal_y_o, normal_z_o, degenerate_o);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = expected_normals.pop_front();
        if (want != {normal_x_o, normal_y_o, normal_z_o, degenerate_o}) begin
          $display("%0t: expected x=%0d y=%0d z=%0d degen=%b, got x=%0d y=%0d z=%0d degen=%b",
                   $time, want.nx, want.ny, want.nz, want.degen,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          mismatch_count <= mismatch_count + 1;
        end
        normals_checked <= normals_checked + 1;
        if (want.degen) degenerate_seen <= degenerate_seen + 1;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one triangle and waits for its transfer; the expectation is queued then.
  task automatic send_triangle(logic signed [15:0] v[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} <=
      {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    do @(posedge clk_i); while (in_stall_o);
    expected_normals = {expected_normals, face_normal(v)};
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every expected result has been checked.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
  endtask

  // APB write of the threshold register; only called while the pipeline is empty.
  task automatic write_threshold(logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THRESHOLD; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    threshold_model = value;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord(int unsigned span);
    if (span >= 16) return 16'($urandom);
    return 16'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  // A random triangle; often small or collinear so degenerate cases show up.
  task automatic send_random_triangle();
    logic signed [15:0] v[9];
    int unsigned span;
    span = $urandom_range(3) == 0 ? 16 : $urandom_range(15, 2);
    foreach (v[i]) v[i] = rand_coord(span);
    if ($urandom_range(9) == 0) begin
      // Collinear: C repeats A or B.
      for (int i = 0; i < 3; i++) v[6 + i] = v[3 * $urandom_range(1) + i];
    end
    send_triangle(v);
  endtask

  // Directed corners: extremes, degenerate shapes, axis-aligned and huge triangles.
  task automatic test_directed();
    logic signed [15:0] v[9];
    v = '{default: 16'sh0000}; send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);
    v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    send_triangle(v);
    v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    send_triangle(v);
    v = '{-32768, 0, 0, 32767, 32767, -32768, 0, -32768, 32767}; send_triangle(v);
    v = '{1, 2, 3, 2, 4, 6, 3, 6, 9}; send_triangle(v);
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_triangle(v);
    v = '{0, 0, 0, 3, 4, 0, 4, -3, 0}; send_triangle(v);
    v = '{-21846, 21845, -1, 21845, -21846, 0, 1, 1, -32768}; send_triangle(v);
    v = '{100, -200, 300, 101, -200, 300, 100, -199, 301}; send_triangle(v);
    drain();
  endtask

  task automatic test_thresholds();
    logic [31:0] levels[5] = '{32'd1, 32'd2, 32'd1000, 32'hFFFF_FFFF, 32'd0};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      repeat (20) send_random_triangle();
      drain();
    end
  endtask

  task automatic test_random_phases();
    int unsigned send_pct[3] = '{7, 50, 0};
    int unsigned recv_pct[3] = '{50, 7, 0};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      write_threshold(p == 1 ? 32'd40 : 32'd0);
      repeat (300) send_random_triangle();
      drain();
    end
  endtask

  // Receiver holds off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_recv = 1'b1;
    repeat (80) send_random_triangle();
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_thresholds();
    test_random_phases();
    test_backpressure();
    $display("checked %0d normals (%0d degenerate) over threshold, stall and idle phases",
             normals_checked, degenerate_seen);
    if (mismatch_count == 0 && expected_normals.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
